>>> src/lag_pkg.sv
`default_nettype none
package lag_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int ROW_W  = MAX_WIDTH;
  localparam int PAD_W  = ROW_W + 2;
  localparam int PAD_AW = $clog2(PAD_W);
  localparam int HEAD_W = $clog2(MAX_HEIGHT);

  localparam int CFG_W   = 7;
  localparam int COUNT_W = 4;

  // B3/S23
  localparam logic [COUNT_W-1:0] SURVIVE_LOW = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] BIRTH_COUNT = COUNT_W'(3);

  localparam logic [1:0] OP_TOGGLE  = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_ADVANCE
  } lag_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
  } lag_item_t;

  typedef struct packed {
    logic               cell_alive;
    logic [COUNT_W-1:0] neighbor_count;
    logic               out_of_range;
  } lag_result_t;

  // Live neighbors of the middle bit of a 3x3 window.
  function automatic logic [COUNT_W-1:0] lag_count(input logic [2:0] above,
                                                   input logic [2:0] cur,
                                                   input logic [2:0] below);
    logic [COUNT_W-1:0] sum;
    sum = COUNT_W'(above[0]) + COUNT_W'(above[1]) + COUNT_W'(above[2])
        + COUNT_W'(cur[0]) + COUNT_W'(cur[2])
        + COUNT_W'(below[0]) + COUNT_W'(below[1]) + COUNT_W'(below[2]);
    return sum;
  endfunction

  function automatic logic lag_alive_next(input logic [2:0] above,
                                          input logic [2:0] cur,
                                          input logic [2:0] below);
    logic [COUNT_W-1:0] n;
    n = lag_count(above, cur, below);
    if (cur[1]) begin
      return (n == SURVIVE_LOW) || (n == BIRTH_COUNT);
    end
    return n == BIRTH_COUNT;
  endfunction

endpackage
`default_nettype wire

>>> src/life_automaton_grid_top.sv
`default_nettype none
// The grid rows sit in a ring of row registers that rotates one row per
// cycle, while an item seeks or advances, past a head position where all
// work happens. A toggle or read first rotates the addressed row to the
// head, as far as the distance from the row currently at the head needs.
// An advance rotates row 0 to the head, then sweeps every row through
// the rule unit at one row per cycle. Out-of-range toggles and reads and
// opcode three finish without a seek. Each item yields one result with
// done high for a single cycle; the receiver cannot stall, so take the
// result in that cycle. Configuration writes are taken only while busy
// is low.
module life_automaton_grid_top
  import lag_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire lag_item_t         item,
  output logic                   done,
  output lag_result_t            result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(MAX_HEIGHT - 1);

  lag_state_t state, state_next;

  logic [CFG_W-1:0]  grid_width;
  logic [CFG_W-1:0]  grid_height;
  logic [CFG_W-1:0]  eff_w;
  logic [CFG_W-1:0]  eff_h;
  logic [ROW_W-1:0]  col_mask;

  logic [ROW_W-1:0]  rows [MAX_HEIGHT];
  logic [HEAD_W-1:0] head_row;
  logic [HEAD_W-1:0] target;
  logic [1:0]        op_code;
  logic [5:0]        op_x;
  logic [ROW_W-1:0]  above_copy;

  logic              accept;
  logic              item_in_range;
  logic              at_target;
  logic              cur_ok;
  logic              below_ok;
  logic [ROW_W-1:0]  row_cur;
  logic [ROW_W-1:0]  row_below;
  logic [ROW_W-1:0]  row_above;
  logic [ROW_W-1:0]  adv_cur;
  logic [ROW_W-1:0]  toggled;
  logic [ROW_W-1:0]  cur_new;
  logic [ROW_W-1:0]  rule_next;
  logic [PAD_W-1:0]  pad_above;
  logic [PAD_W-1:0]  pad_cur;
  logic [PAD_W-1:0]  pad_below;
  logic [PAD_AW-1:0] pad_idx;
  logic [COUNT_W-1:0] read_count;

  logic              rotate;
  logic [ROW_W-1:0]  tail_in;
  logic              head_load;
  logic              done_next;
  lag_result_t       result_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = start && !busy;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_W'(MAX_WIDTH);
      grid_height <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
      endcase
    end
  end

  // clamp to the physical grid
  assign eff_w = (32'(grid_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : grid_width;
  assign eff_h = (32'(grid_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : grid_height;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      col_mask[i] = (32'(i) < 32'(eff_w));
    end
  end

  assign item_in_range = (32'(item.cell_x) < 32'(eff_w)) && (32'(item.cell_y) < 32'(eff_h));

  // row ring: cell i takes cell i+1, the last cell takes the tail input
  for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_row
    if (i == MAX_HEIGHT - 1) begin : g_tail
      lag_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (rotate),
        .shift_in  (tail_in),
        .load      (1'b0),
        .load_data (toggled),
        .row       (rows[i])
      );
    end else if (i == 0) begin : g_head
      lag_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (rotate),
        .shift_in  (rows[i+1]),
        .load      (head_load),
        .load_data (toggled),
        .row       (rows[i])
      );
    end else begin : g_mid
      lag_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (rotate),
        .shift_in  (rows[i+1]),
        .load      (1'b0),
        .load_data (toggled),
        .row       (rows[i])
      );
    end
  end

  // window around the head row
  assign at_target = (head_row == target);
  assign cur_ok    = (32'(head_row) < 32'(eff_h));
  assign below_ok  = (32'(head_row) + 32'd1 < 32'(eff_h));
  assign row_cur   = rows[0] & col_mask;
  assign row_below = below_ok ? (rows[1] & col_mask) : '0;
  assign row_above = (head_row != '0) ? (rows[MAX_HEIGHT-1] & col_mask) : '0;
  assign adv_cur   = cur_ok ? row_cur : '0;

  assign toggled = rows[0] ^ (ROW_W'(1) << op_x);
  assign cur_new = (op_code == OP_TOGGLE) ? (toggled & col_mask) : row_cur;

  assign pad_above  = {1'b0, row_above, 1'b0};
  assign pad_cur    = {1'b0, cur_new, 1'b0};
  assign pad_below  = {1'b0, row_below, 1'b0};
  assign pad_idx    = PAD_AW'(op_x);
  assign read_count = lag_count(pad_above[pad_idx +: 3], pad_cur[pad_idx +: 3],
                                pad_below[pad_idx +: 3]);

  lag_rule u_rule (
    .above    (above_copy),
    .cur      (adv_cur),
    .below    (row_below),
    .col_mask (col_mask),
    .next_row (rule_next)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.opcode == OP_ADVANCE) begin
            state_next = ST_SEEK;
          end else if (item.opcode != OP_NONE && item_in_range) begin
            state_next = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        if (at_target) begin
          state_next = (op_code == OP_ADVANCE) ? ST_ADVANCE : ST_IDLE;
        end
      end
      ST_ADVANCE: begin
        if (head_row == HEAD_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rotate      = 1'b0;
    tail_in     = rows[0];
    head_load   = 1'b0;
    done_next   = 1'b0;
    result_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.opcode == OP_NONE) begin
            done_next = 1'b1;
          end else if (item.opcode != OP_ADVANCE && !item_in_range) begin
            done_next                = 1'b1;
            result_next.out_of_range = 1'b1;
          end
        end
      end
      ST_SEEK: begin
        if (!at_target) begin
          rotate = 1'b1;
        end else if (op_code != OP_ADVANCE) begin
          head_load                  = (op_code == OP_TOGGLE);
          done_next                  = 1'b1;
          result_next.cell_alive     = cur_new[op_x];
          result_next.neighbor_count = read_count;
        end
      end
      ST_ADVANCE: begin
        rotate    = 1'b1;
        tail_in   = cur_ok ? rule_next : '0;
        done_next = (head_row == HEAD_LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head_row <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (rotate) begin
        head_row <= (head_row == HEAD_LAST) ? '0 : head_row + HEAD_W'(1);
      end
    end
  end

  // hold the transaction and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_code <= item.opcode;
      op_x    <= item.cell_x;
      target  <= (item.opcode == OP_ADVANCE) ? '0 : HEAD_W'(item.cell_y);
    end
    if (done_next) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above_copy <= '0;
    end else if (state == ST_SEEK) begin
      above_copy <= '0;
    end else if (state == ST_ADVANCE) begin
      above_copy <= adv_cur;
    end
  end

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe while a transaction is in flight");

  a_sweep_from_top : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEEK) && (state_next == ST_ADVANCE) |=> (head_row == '0))
    else $error("generation sweep did not start at row 0");

  a_sweep_full : assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADVANCE) && (state_next == ST_IDLE) |=> (head_row == '0) && done)
    else $error("generation sweep ended off the ring origin");

  a_seek_on_target : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEEK) && (state_next == ST_IDLE) |-> (head_row == target) && done_next)
    else $error("cell access finished away from the addressed row");

endmodule
`default_nettype wire

>>> src/lag_cell.sv
`default_nettype none
module lag_cell
  import lag_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift,
  input  wire logic [ROW_W-1:0] shift_in,
  input  wire logic             load,
  input  wire logic [ROW_W-1:0] load_data,
  output logic      [ROW_W-1:0] row
);

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (load) begin
      row <= load_data;
    end else if (shift) begin
      row <= shift_in;
    end
  end

endmodule
`default_nettype wire

>>> src/lag_rule.sv
`default_nettype none
module lag_rule
  import lag_pkg::*;
(
  input  wire logic [ROW_W-1:0] above,
  input  wire logic [ROW_W-1:0] cur,
  input  wire logic [ROW_W-1:0] below,
  input  wire logic [ROW_W-1:0] col_mask,
  output logic      [ROW_W-1:0] next_row
);

  logic [PAD_W-1:0] pad_above;
  logic [PAD_W-1:0] pad_cur;
  logic [PAD_W-1:0] pad_below;

  // pad with dead columns so the edges need no special lanes
  assign pad_above = {1'b0, above, 1'b0};
  assign pad_cur   = {1'b0, cur, 1'b0};
  assign pad_below = {1'b0, below, 1'b0};

  for (genvar i = 0; i < ROW_W; i++) begin : g_lane
    assign next_row[i] = col_mask[i] &
                         lag_alive_next(pad_above[i +: 3], pad_cur[i +: 3], pad_below[i +: 3]);
  end

endmodule
`default_nettype wire

>>> bench/life_automaton_grid_top_test.sv
`timescale 1ns / 100ps

module life_automaton_grid_top_test;
  import lag_pkg::*;

  class life_shadow_grid;
    bit [ROW_W-1:0] grid [MAX_HEIGHT];
    bit [CFG_W-1:0] width_reg;
    bit [CFG_W-1:0] height_reg;
    lag_result_t awaited_results [$];
    int errors;
    int checked;
    int items;
    int generations;
    int outside;

    function new();
      foreach (grid[r]) grid[r] = '0;
      width_reg  = CFG_W'(MAX_WIDTH);
      height_reg = CFG_W'(MAX_HEIGHT);
    endfunction

    function void write_reg(logic idx, bit [CFG_W-1:0] value);
      if (idx == CFG_GRID_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    function int cols_in_use();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function int rows_in_use();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function bit [ROW_W-1:0] col_mask(int w);
      if (w >= ROW_W) return '1;
      return (ROW_W'(1) << w) - ROW_W'(1);
    endfunction

    function bit cell_of(bit [ROW_W-1:0] word, int x);
      if (x < 0 || x >= ROW_W) return 1'b0;
      return word[x];
    endfunction

    // Rows outside the grid in use read as dead.
    function bit [ROW_W-1:0] live_row(int y, int w, int h);
      if (y < 0 || y >= h) return '0;
      return grid[y] & col_mask(w);
    endfunction

    function int neighbors(bit [ROW_W-1:0] above, bit [ROW_W-1:0] cur,
                           bit [ROW_W-1:0] below, int x);
      return cell_of(above, x - 1) + cell_of(above, x) + cell_of(above, x + 1)
           + cell_of(cur, x - 1) + cell_of(cur, x + 1)
           + cell_of(below, x - 1) + cell_of(below, x) + cell_of(below, x + 1);
    endfunction

    function void step_generation();
      bit [ROW_W-1:0] above, cur, below, nxt, mask;
      int w, h, n;
      w = cols_in_use();
      h = rows_in_use();
      mask = col_mask(w);
      above = '0;
      // Rewrite rows in order; keep the old row above for the next one.
      for (int r = 0; r < MAX_HEIGHT; r++) begin
        cur   = (r < h) ? (grid[r] & mask) : '0;
        below = (r + 1 < h) ? (grid[r + 1] & mask) : '0;
        nxt   = '0;
        if (r < h) begin
          for (int x = 0; x < w; x++) begin
            n = neighbors(above, cur, below, x);
            if (cur[x]) nxt[x] = (n == SURVIVE_LOW) || (n == BIRTH_COUNT);
            else nxt[x] = (n == BIRTH_COUNT);
          end
        end
        above = cur;
        grid[r] = nxt;
      end
    endfunction

    function void note_item(lag_item_t it);
      lag_result_t expd;
      int x, y, w, h;
      expd = '0;
      x = it.cell_x;
      y = it.cell_y;
      w = cols_in_use();
      h = rows_in_use();
      items++;
      case (it.opcode)
        OP_ADVANCE: begin
          step_generation();
          generations++;
        end
        OP_NONE: ;
        default: begin
          if (x >= w || y >= h) begin
            expd.out_of_range = 1'b1;
            outside++;
          end else begin
            if (it.opcode == OP_TOGGLE) grid[y][x] = ~grid[y][x];
            expd.cell_alive = cell_of(live_row(y, w, h), x);
            expd.neighbor_count = COUNT_W'(neighbors(live_row(y - 1, w, h),
                                                     live_row(y, w, h),
                                                     live_row(y + 1, w, h), x));
          end
        end
      endcase
      awaited_results.push_back(expd);
    endfunction

    function void check_result(lag_result_t got);
      lag_result_t expd;
      if (awaited_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: alive=%0b count=%0d oor=%0b",
                   got.cell_alive, got.neighbor_count, got.out_of_range);
        errors++;
        return;
      end
      expd = awaited_results.pop_front();
      checked++;
      if (got.cell_alive !== expd.cell_alive ||
          got.neighbor_count !== expd.neighbor_count ||
          got.out_of_range !== expd.out_of_range) begin
        if (errors < 10)
          $display("mismatch on result %0d: expected alive=%0b count=%0d oor=%0b, got alive=%0b count=%0d oor=%0b",
                   checked, expd.cell_alive, expd.neighbor_count, expd.out_of_range,
                   got.cell_alive, got.neighbor_count, got.out_of_range);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * MAX_HEIGHT + 20;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  lag_item_t         item;
  logic              done;
  lag_result_t       result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  life_shadow_grid sb;
  int reg_writes;
  int settings;

  life_automaton_grid_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("no transaction for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Leave start high on return so back-to-back items need no extra edge.
  task automatic issue(input logic [1:0] op, input int x, input int y);
    lag_item_t it;
    it.opcode = op;
    it.cell_x = 6'(x);
    it.cell_y = 6'(y);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(input bit [CFG_W-1:0] cols, input bit [CFG_W-1:0] rows_n);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= cols;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(CFG_GRID_WIDTH, cols);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= rows_n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(CFG_GRID_HEIGHT, rows_n);
    cfg_valid <= 1'b0;
    reg_writes += 2;
    settings++;
  endtask

  initial begin : stimulus
    bit [CFG_W-1:0] fixed_w [8];
    bit [CFG_W-1:0] fixed_h [8];
    bit [CFG_W-1:0] cw, ch;
    logic [1:0] op;
    int w, h, ww, wh, wx0, wy0, x, y, roll, spot;
    bit calm;

    fixed_w = '{7'd3, 7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd64, 7'd7};
    fixed_h = '{7'd3, 7'd9, 7'd1, 7'd127, 7'd4, 7'd64, 7'd0, 7'd127};
    sb = new();
    reg_writes = 0;
    settings = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full grid after reset: corners, a blinker and its two phases.
    issue(OP_READ, 0, 0);
    issue(OP_TOGGLE, 0, 0);
    issue(OP_TOGGLE, 63, 63);
    issue(OP_TOGGLE, 63, 0);
    issue(OP_TOGGLE, 0, 63);
    issue(OP_READ, 1, 1);
    issue(OP_TOGGLE, 10, 10);
    issue(OP_TOGGLE, 11, 10);
    issue(OP_TOGGLE, 12, 10);
    issue(OP_READ, 11, 10);
    issue(OP_READ, 11, 9);
    issue(OP_ADVANCE, 0, 0);
    issue(OP_READ, 11, 11);
    issue(OP_NONE, 63, 63);
    issue(OP_ADVANCE, 63, 63);
    issue(OP_TOGGLE, 11, 10);
    issue(OP_TOGGLE, 11, 10);
    issue(OP_READ, 11, 10);
    // Narrow grid: addresses past the edge, then clear what lies beyond it.
    settle();
    configure(7'd5, 7'd4);
    issue(OP_TOGGLE, 5, 0);
    issue(OP_READ, 0, 4);
    issue(OP_READ, 4, 3);
    issue(OP_ADVANCE, 0, 0);
    // Empty grid: everything is out of range and an advance clears all.
    settle();
    configure(7'd0, 7'd0);
    issue(OP_TOGGLE, 0, 0);
    issue(OP_ADVANCE, 0, 0);

    for (int phase = 0; phase < 14; phase++) begin
      if (phase < 8) begin
        cw = fixed_w[phase];
        ch = fixed_h[phase];
      end else if ($urandom_range(0, 3) == 0) begin
        cw = CFG_W'($urandom_range(0, 127));
        ch = CFG_W'($urandom_range(0, 127));
      end else begin
        cw = CFG_W'($urandom_range(1, 12));
        ch = CFG_W'($urandom_range(1, 12));
      end
      settle();
      configure(cw, ch);
      w = sb.cols_in_use();
      h = sb.rows_in_use();
      // Focus most activity on a small patch so patterns actually evolve.
      ww = (w < 6) ? w : 6;
      wh = (h < 6) ? h : 6;
      wx0 = (w > 0) ? $urandom_range(0, w - ww) : 0;
      wy0 = (h > 0) ? $urandom_range(0, h - wh) : 0;
      calm = (phase >= 12);
      for (int k = 0; k < 66; k++) begin
        if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 12));
        roll = $urandom_range(0, 99);
        if (roll < 10) op = OP_ADVANCE;
        else if (roll < 13) op = OP_NONE;
        else if (roll < 60) op = OP_TOGGLE;
        else op = OP_READ;
        spot = $urandom_range(0, 99);
        if (w == 0 || h == 0 || spot < 10) begin
          x = $urandom_range(0, 63);
          y = $urandom_range(0, 63);
        end else if (spot < 35) begin
          x = $urandom_range(0, w - 1);
          y = $urandom_range(0, h - 1);
        end else begin
          x = wx0 + $urandom_range(0, ww - 1);
          y = wy0 + $urandom_range(0, wh - 1);
        end
        issue(op, x, y);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    $display("covered %0d items over %0d grid sizes: %0d generations, %0d out-of-range",
             sb.items, settings, sb.generations, sb.outside);
    $display("checked %0d results after %0d register writes, %0d mismatches",
             sb.checked, reg_writes, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
